// ===== hdl/trapezoid_velocity_profile_unit_macros.svh =====
// Assertion macros for the trapezoid profile unit.
// Included by the top level only; depends on nothing else.
`ifndef TRAPEZOID_VELOCITY_PROFILE_UNIT_MACROS_SVH
`define TRAPEZOID_VELOCITY_PROFILE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TRAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/trap_pkg.sv =====
// Shared types and constants of the trapezoid profile unit.
// Used by trapezoid_velocity_profile_unit; depends on nothing.
package trap_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int IN_DATA_WIDTH   = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_POSITION  = 3'd0,
        REG_END_POSITION    = 3'd1,
        REG_START_VELOCITY  = 3'd2,
        REG_FINAL_VELOCITY  = 3'd3,
        REG_CRUISE_VELOCITY = 3'd4,
        REG_ACCEL_TICKS     = 3'd5,
        REG_DECEL_TICKS     = 3'd6,
        REG_TOTAL_TICKS     = 3'd7
    } cfg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PHASE = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_VEL   = 8'b0000_1000,
        ST_DIST  = 8'b0001_0000,
        ST_STEP  = 8'b0010_0000,
        ST_POS   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

endpackage

// ===== hdl/trap_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero; a zero divisor gives zero. No package dependency.
module trap_div #(
    parameter int NUM_WIDTH = 33,
    parameter int DEN_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [NUM_WIDTH-1:0] num,
    input  logic        [DEN_WIDTH-1:0] den,
    output logic                        done,
    output logic signed [NUM_WIDTH-1:0] quo
);

    localparam int CNT_WIDTH = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    logic                        busy_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic                        zden_reg;
    logic [CNT_WIDTH-1:0]        cnt_reg;
    logic [NUM_WIDTH-1:0]        dvd_reg;
    logic [DEN_WIDTH-1:0]        rem_reg;
    logic [DEN_WIDTH-1:0]        den_reg;
    logic signed [NUM_WIDTH-1:0] quo_reg;

    logic [NUM_WIDTH-1:0] mag;
    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH:0]   diff;
    logic                 ge;

    assign mag   = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    assign trial = {rem_reg, dvd_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = !diff[DEN_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg && !start && !busy_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(NUM_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= mag;
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= num[NUM_WIDTH-1];
            zden_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, keep the quotient bit on the right
            rem_reg <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            dvd_reg <= {dvd_reg[NUM_WIDTH-2:0], ge};
        end
        else if (fin_reg)
        begin
            if (zden_reg)
                quo_reg <= '0;
            else if (neg_reg)
                quo_reg <= NUM_WIDTH'(-dvd_reg);
            else
                quo_reg <= dvd_reg;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/trapezoid_velocity_profile_unit.sv =====
// Channel    Dir  Handshake          Payload
// s_         in   s_tvalid/s_tready  s_tdata[0] restart
// m_         out  m_tvalid/m_tready  m_tdata position, velocity; m_tlast last_point
// cfg_       in   cfg_we             cfg_index, cfg_data
// Accel and decel ticks wait on the divider, which gives one quotient bit per cycle;
// cruise ticks skip it, and ticks that give no result are dropped while idle.
// One tick is worked on at a time; s_tready is high only while the sequencer idles.
// A finished point waits in the output register until taken; a new tick is accepted
// meanwhile, and its point waits in the last step until the register frees.
// Reset clears config, state, position, velocity and tick, not payload; no clearing pass needed.
// Depends on trap_pkg, trap_div and trapezoid_velocity_profile_unit_macros.svh.
`include "trapezoid_velocity_profile_unit_macros.svh"

module trapezoid_velocity_profile_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [trap_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [((VALUE_WIDTH > COUNT_WIDTH) ? VALUE_WIDTH : COUNT_WIDTH)-1:0] cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [trap_pkg::IN_DATA_WIDTH-1:0]     s_tdata,  // [0] restart
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // position (lowest), velocity, then zero fill
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic                                   m_tlast   // last_point
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int OW = ((2*VALUE_WIDTH+7)/8)*8;

    // configuration
    logic signed [VW-1:0] start_pos_reg;
    logic signed [VW-1:0] end_pos_reg;
    logic signed [VW-1:0] start_vel_reg;
    logic signed [VW-1:0] final_vel_reg;
    logic signed [VW-1:0] cruise_vel_reg;
    logic [CW-1:0]        accel_reg;
    logic [CW-1:0]        decel_reg;
    logic [CW-1:0]        total_reg;

    // profile state
    trap_pkg::state_t     state_reg;
    trap_pkg::state_t     state_next;
    logic signed [VW-1:0] pos_reg;
    logic signed [VW-1:0] vel_reg;
    logic [CW-1:0]        tick_reg;
    logic                 active_reg;
    logic                 last_reg;
    logic signed [VW:0]   dist_reg;
    logic [VW:0]          mag_reg;
    logic                 dir_pos_reg;
    logic signed [VW:0]   step_reg;

    // output register
    logic                 m_valid_reg;
    logic signed [VW-1:0] m_pos_reg;
    logic signed [VW-1:0] m_vel_reg;
    logic                 m_last_reg;

    logic                 in_beat;
    logic                 restart;
    logic [CW-1:0]        tick_ld;
    logic                 go;
    logic                 in_accel;
    logic                 in_cruise;
    logic [CW:0]          tick_dec;
    logic [CW:0]          tick_inc;
    logic signed [VW:0]   acc_num;
    logic signed [VW:0]   dec_num;
    logic                 div_start;
    logic signed [VW:0]   div_num;
    logic [CW-1:0]        div_den;
    logic                 div_done;
    logic signed [VW:0]   div_quo;
    logic signed [VW+1:0] vel_sum;
    logic signed [VW:0]   dist_d;
    logic signed [VW:0]   ndist_d;
    logic signed [VW:0]   span;
    logic signed [VW:0]   vel_ext;
    logic signed [VW:0]   nvel_ext;
    logic                 mag_gt;
    logic signed [VW+1:0] pos_sum;
    logic                 out_free;

    function automatic logic signed [VW-1:0] sat_val(input logic signed [VW+1:0] s);
        logic signed [VW-1:0] r;
        if (!s[VW+1] && (s[VW:VW-1] != 2'b00))
            r = {1'b0, {(VW-1){1'b1}}};
        else if (s[VW+1] && (s[VW:VW-1] != 2'b11))
            r = {1'b1, {(VW-1){1'b0}}};
        else
            r = s[VW-1:0];
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg  <= '0;
            end_pos_reg    <= '0;
            start_vel_reg  <= '0;
            final_vel_reg  <= '0;
            cruise_vel_reg <= '0;
            accel_reg      <= '0;
            decel_reg      <= '0;
            total_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (trap_pkg::cfg_index_t'(cfg_index))
                trap_pkg::REG_START_POSITION:  start_pos_reg  <= cfg_data[VW-1:0];
                trap_pkg::REG_END_POSITION:    end_pos_reg    <= cfg_data[VW-1:0];
                trap_pkg::REG_START_VELOCITY:  start_vel_reg  <= cfg_data[VW-1:0];
                trap_pkg::REG_FINAL_VELOCITY:  final_vel_reg  <= cfg_data[VW-1:0];
                trap_pkg::REG_CRUISE_VELOCITY: cruise_vel_reg <= cfg_data[VW-1:0];
                trap_pkg::REG_ACCEL_TICKS:     accel_reg      <= cfg_data[CW-1:0];
                trap_pkg::REG_DECEL_TICKS:     decel_reg      <= cfg_data[CW-1:0];
                trap_pkg::REG_TOTAL_TICKS:     total_reg      <= cfg_data[CW-1:0];
            endcase
        end
    end

    assign s_tready = (state_reg == trap_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign restart  = s_tdata[0];
    assign tick_ld  = restart ? '0 : tick_reg;
    assign go       = (restart || active_reg) && (tick_ld < total_reg);

    assign in_accel  = tick_reg < accel_reg;
    assign tick_dec  = {1'b0, tick_reg} + {1'b0, decel_reg};
    assign in_cruise = tick_dec < {1'b0, total_reg};
    assign tick_inc  = {1'b0, tick_reg} + {{CW{1'b0}}, 1'b1};
    // decel numerator is negated so both ramps add their quotient
    assign acc_num   = {cruise_vel_reg[VW-1], cruise_vel_reg}
                     - {start_vel_reg[VW-1], start_vel_reg};
    assign dec_num   = {final_vel_reg[VW-1], final_vel_reg}
                     - {cruise_vel_reg[VW-1], cruise_vel_reg};
    assign div_start = (state_reg == trap_pkg::ST_PHASE) && (in_accel || !in_cruise);
    assign div_num   = in_accel ? acc_num : dec_num;
    assign div_den   = in_accel ? accel_reg : decel_reg;

    trap_div #(
        .NUM_WIDTH (VW + 1),
        .DEN_WIDTH (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign vel_sum  = {{2{vel_reg[VW-1]}}, vel_reg} + {div_quo[VW], div_quo};
    assign dist_d   = {end_pos_reg[VW-1], end_pos_reg} - {pos_reg[VW-1], pos_reg};
    assign ndist_d  = {pos_reg[VW-1], pos_reg} - {end_pos_reg[VW-1], end_pos_reg};
    assign span     = {end_pos_reg[VW-1], end_pos_reg} - {start_pos_reg[VW-1], start_pos_reg};
    assign vel_ext  = {vel_reg[VW-1], vel_reg};
    assign nvel_ext = -vel_ext;
    assign mag_gt   = $signed({1'b0, mag_reg}) > $signed({vel_reg[VW-1], vel_ext});
    assign pos_sum  = {{2{pos_reg[VW-1]}}, pos_reg} + {step_reg[VW], step_reg};
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trap_pkg::ST_IDLE:
                if (in_beat && go)
                    state_next = trap_pkg::ST_PHASE;
            trap_pkg::ST_PHASE:
                state_next = div_start ? trap_pkg::ST_DIV : trap_pkg::ST_DIST;
            trap_pkg::ST_DIV:
                if (div_done)
                    state_next = trap_pkg::ST_VEL;
            trap_pkg::ST_VEL:  state_next = trap_pkg::ST_DIST;
            trap_pkg::ST_DIST: state_next = trap_pkg::ST_STEP;
            trap_pkg::ST_STEP: state_next = trap_pkg::ST_POS;
            trap_pkg::ST_POS:  state_next = trap_pkg::ST_OUT;
            trap_pkg::ST_OUT:
                if (out_free)
                    state_next = trap_pkg::ST_IDLE;
            default: state_next = trap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= trap_pkg::ST_IDLE;
            pos_reg     <= '0;
            vel_reg     <= '0;
            tick_reg    <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // load a finished point, or drop the taken one
            if ((state_reg == trap_pkg::ST_OUT) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                trap_pkg::ST_IDLE:
                    if (in_beat)
                    begin
                        if (restart)
                        begin
                            pos_reg  <= start_pos_reg;
                            vel_reg  <= start_vel_reg;
                            tick_reg <= '0;
                        end
                        active_reg <= go;
                    end
                trap_pkg::ST_PHASE:
                    if (!in_accel && in_cruise)
                        vel_reg <= cruise_vel_reg;
                trap_pkg::ST_VEL:
                    vel_reg <= sat_val(vel_sum);
                trap_pkg::ST_POS:
                begin
                    pos_reg  <= sat_val(pos_sum);
                    tick_reg <= tick_inc[CW-1:0];
                    if (last_reg)
                        active_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == trap_pkg::ST_PHASE)
            last_reg <= (tick_inc == {1'b0, total_reg});
        if (state_reg == trap_pkg::ST_DIST)
        begin
            dist_reg    <= dist_d;
            mag_reg     <= dist_d[VW] ? ndist_d : dist_d;
            dir_pos_reg <= !span[VW] && (span != '0);
        end
        if (state_reg == trap_pkg::ST_STEP)
        begin
            // land on the end position once it is within one velocity step
            if (mag_gt)
                step_reg <= dir_pos_reg ? vel_ext : nvel_ext;
            else
                step_reg <= dist_reg;
        end
        if ((state_reg == trap_pkg::ST_OUT) && out_free)
        begin
            m_pos_reg  <= pos_reg;
            m_vel_reg  <= vel_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OW'({m_vel_reg, m_pos_reg});
    assign m_tlast  = m_last_reg;

    `TRAP_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_done,
        state_reg == trap_pkg::ST_DIV, "divider finished outside its wait state")

    `TRAP_ASSERT_NEXT(a_last_ends_run, clk, rst_n,
        (state_reg == trap_pkg::ST_POS) && last_reg, !active_reg,
        "profile still active after its last point")

    `TRAP_ASSERT_NEXT(a_idle_tick_dropped, clk, rst_n,
        in_beat && !restart && !active_reg, state_reg == trap_pkg::ST_IDLE,
        "tick without restart started work while idle")

    `TRAP_ASSERT_NEXT(a_hold_pending_point, clk, rst_n,
        (state_reg == trap_pkg::ST_OUT) && m_valid_reg && !m_tready,
        (state_reg == trap_pkg::ST_OUT) && m_valid_reg,
        "pending point overrun while output stalled")

endmodule
